FILE: rtl/tak_pkg.sv
`timescale 1ns / 1ps
package tak_pkg;

   localparam int DATA_BITS = 32;
   localparam int CFG_BITS  = 31;
   localparam int FRAC_BITS = 30;
   // wide enough for any state value plus any rounded product
   localparam int SUM_BITS  = 66;

   localparam logic [CFG_BITS-1:0] ANGLE_NOISE_RST = 31'd1073742;
   localparam logic [CFG_BITS-1:0] BIAS_NOISE_RST  = 31'd3221225;
   localparam logic [CFG_BITS-1:0] MEAS_NOISE_RST  = 31'd536870912;
   localparam logic [CFG_BITS-1:0] TIME_STEP_RST   = 31'd5368709;

   typedef enum logic [1:0] {
      CSR_ANGLE_NOISE = 2'd0,
      CSR_BIAS_NOISE  = 2'd1,
      CSR_MEAS_NOISE  = 2'd2,
      CSR_TIME_STEP   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   typedef enum logic [3:0] {
      ST_ANGLE_PRED  = 4'd0,
      ST_AA_PRED     = 4'd1,
      ST_ABBA_PRED   = 4'd2,
      ST_BB_PRED     = 4'd3,
      ST_GAIN_ANGLE  = 4'd4,
      ST_GAIN_BIAS   = 4'd5,
      ST_AA_UPD      = 4'd6,
      ST_AB_UPD      = 4'd7,
      ST_BA_UPD      = 4'd8,
      ST_BB_UPD      = 4'd9,
      ST_ANGLE_UPD   = 4'd10,
      ST_BIAS_UPD    = 4'd11
   } step_type;

   function automatic logic signed [DATA_BITS-1:0] sat32(input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'(64'sh7FFF_FFFF);
      lo = -hi - SUM_BITS'(1);
      if (v > hi) return hi[DATA_BITS-1:0];
      if (v < lo) return lo[DATA_BITS-1:0];
      return v[DATA_BITS-1:0];
   endfunction

endpackage

FILE: rtl/tak_if.sv
`timescale 1ns / 1ps
interface tak_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_angle;
   logic signed [31:0] gyro_rate;
   modport source (output valid, accel_angle, gyro_rate, input ready);
   modport sink   (input valid, accel_angle, gyro_rate, output ready);
endinterface

interface tak_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] angle_estimate;
   logic signed [31:0] rate_estimate;
   logic signed [31:0] bias_estimate;
   modport source (output valid, angle_estimate, rate_estimate, bias_estimate, input ready);
   modport sink   (input valid, angle_estimate, rate_estimate, bias_estimate, output ready);
endinterface

FILE: rtl/tak_mul.sv
`timescale 1ns / 1ps
// (a*b) >> 30, round half away from zero, magnitude clamped to 2^62.
// b is consumed 16 bits a cycle, top chunk first.
module tak_mul
   import tak_pkg::*;
#(
   parameter int OW = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [OW-1:0] a,
   input  logic signed [OW-1:0] b,
   output logic                 done,
   output logic signed [63:0]   prod
);
   localparam int NCH = (OW + 15) / 16;
   localparam int YW  = NCH * 16;
   localparam int PW  = OW + YW;
   localparam int RW  = PW + 1;
   localparam int CW  = $clog2(NCH + 1);

   logic [OW-1:0]        x_ff;
   logic [YW-1:0]        y_ff;
   logic [PW-1:0]        acc_ff, acc_in;
   logic                 neg_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 run_ff, fin_ff, done_ff;
   logic signed [63:0]   prod_ff, prod_in;
   logic [OW-1:0]        mag_a, mag_b;
   logic [OW+15:0]       pp;
   logic [RW-1:0]        rnd;
   logic                 last;

   assign mag_a = a[OW-1] ? (~a + 1'b1) : a;
   assign mag_b = b[OW-1] ? (~b + 1'b1) : b;
   assign pp    = x_ff * y_ff[YW-1 -: 16];
   assign acc_in = (acc_ff << 16) + PW'(pp);
   assign last  = (cnt_ff == CW'(NCH - 1));

   always_comb begin
      rnd = ({1'b0, acc_ff} + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (rnd > (RW'(1) << 62)) rnd = RW'(1) << 62;
      prod_in = neg_ff ? -$signed(64'(rnd[62:0])) : $signed(64'(rnd[62:0]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && last;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= mag_a;
         y_ff   <= YW'(mag_b);
         acc_ff <= '0;
         neg_ff <= a[OW-1] ^ b[OW-1];
      end else if (run_ff) begin
         acc_ff <= acc_in;
         y_ff   <= y_ff << 16;
      end
      if (fin_ff) prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

FILE: rtl/tak_div.sv
`timescale 1ns / 1ps
// (n << 30) / d for d > 0, restoring, one quotient bit a cycle.
// Quotient truncated toward zero and saturated to NW bits.
module tak_div
   import tak_pkg::*;
#(
   parameter int NW   = 32,
   parameter int DENW = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] n,
   input  logic [DENW-1:0]      d,
   output logic                 done,
   output logic signed [NW-1:0] q
);
   localparam int DW = NW + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [DW-1:0] LIMIT = (DW'(1) << (NW - 1)) - DW'(1);

   logic [DW-1:0]        num_ff;
   logic [DW-1:0]        quo_ff;
   logic [DENW:0]        rem_ff;
   logic [DENW-1:0]      den_ff;
   logic                 neg_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 run_ff, fin_ff, done_ff;
   logic signed [NW-1:0] q_ff, q_in;
   logic [NW-1:0]        mag_n;
   logic [DENW:0]        rem_sh;
   logic                 fits;
   logic [NW-1:0]        qs;
   logic                 last;

   assign mag_n  = n[NW-1] ? (~n + 1'b1) : n;
   assign rem_sh = {rem_ff[DENW-1:0], num_ff[DW-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});
   assign last   = (cnt_ff == CW'(DW - 1));

   always_comb begin
      qs   = (quo_ff > LIMIT) ? LIMIT[NW-1:0] : quo_ff[NW-1:0];
      q_in = neg_ff ? -$signed(qs) : $signed(qs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= fin_ff;
         fin_ff  <= run_ff && last;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (last) run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {mag_n, {FRAC_BITS{1'b0}}};
         quo_ff <= '0;
         rem_ff <= '0;
         den_ff <= d;
         neg_ff <= n[NW-1];
      end else if (run_ff) begin
         num_ff <= num_ff << 1;
         quo_ff <= {quo_ff[DW-2:0], fits};
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      end
      if (fin_ff) q_ff <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;
endmodule

FILE: rtl/tilt_angle_kalman_filter_top.sv
`timescale 1ns / 1ps
// Two-state tilt Kalman filter (angle, gyro bias) with a 2x2 covariance.
// req_ch takes one beat per sample: accelerometer angle and gyro rate, Q16.16.
// rsp_ch gives one beat per sample: filtered angle, bias-corrected rate, bias.
// csr_we/csr_addr/csr_wdata write the Q1.30 noise terms and the time step;
// write them only while the filter is idle.
// One sample runs through a sequencer that drives a single shared multiplier
// (16 bits of one operand a cycle) ten times and a bit-serial divider twice.
// When the innovation variance is not positive, both divides are skipped.
// The divider takes most of the time of a sample.
// One sample at a time: req_ch.ready is high only when the sequencer is idle,
// so a new beat is taken only after the last sample has left the sequencer.
// The response sits in an output register; a new sample is taken while it
// waits, and a finished sample holds in the sequencer until it is drained.
// Reset (synchronous) restores the register defaults, zeroes angle and bias,
// sets the covariance to identity and drops any pending response.
module tilt_angle_kalman_filter_top
   import tak_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   tak_req_if.sink             req_ch,
   tak_rsp_if.source           rsp_ch,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CFG_BITS-1:0] csr_wdata
);
   localparam int BW   = (WORD_BITS > 32) ? WORD_BITS : 32;
   localparam int OW   = BW + 2;
   localparam int EW   = BW + 1;
   localparam int DENW = BW;
   localparam logic signed [SUM_BITS-1:0] W_MAX =
      $signed({{(SUM_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
   localparam logic signed [SUM_BITS-1:0] W_MIN = ~W_MAX;
   localparam logic signed [WORD_BITS-1:0] ONE_COV = (WORD_BITS > 31)
      ? WORD_BITS'(64'sd1 <<< FRAC_BITS) : W_MAX[WORD_BITS-1:0];

   function automatic logic signed [WORD_BITS-1:0] sat_w(input logic signed [SUM_BITS-1:0] v);
      if (v > W_MAX) return W_MAX[WORD_BITS-1:0];
      if (v < W_MIN) return W_MIN[WORD_BITS-1:0];
      return v[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [WORD_BITS-1:0] acc_w(input logic signed [WORD_BITS-1:0] cur,
                                                         input logic signed [63:0] r,
                                                         input logic sub);
      logic signed [SUM_BITS-1:0] s;
      s = sub ? (SUM_BITS'(cur) - SUM_BITS'(r)) : (SUM_BITS'(cur) + SUM_BITS'(r));
      return sat_w(s);
   endfunction

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   logic      busy_ff, busy_in;
   logic [CFG_BITS-1:0] apn_ff, apn_in, bpn_ff, bpn_in, mn_ff, mn_in, dt_ff, dt_in;
   logic signed [31:0] accel_ff, accel_in, gyro_ff, gyro_in;
   logic signed [WORD_BITS-1:0] angle_ff, angle_in, bias_ff, bias_in;
   logic signed [WORD_BITS-1:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;
   logic signed [WORD_BITS-1:0] k0_ff, k0_in, k1_ff, k1_in, t0_ff, t0_in, t1_ff, t1_in;
   logic signed [OW-1:0] err_ff, err_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_angle_ff, out_angle_in, out_rate_ff, out_rate_in;
   logic signed [31:0] out_bias_ff, out_bias_in;

   logic signed [OW-1:0] mul_a, mul_b, dt_op;
   logic                 mul_start, mul_done;
   logic signed [63:0]   mul_prod;
   logic signed [EW-1:0] e;
   logic                 e_pos;
   logic signed [WORD_BITS-1:0] div_n, div_q;
   logic                 div_start, div_done;

   assign dt_op = OW'($signed({1'b0, dt_ff}));
   assign e     = EW'($signed({1'b0, mn_ff})) + EW'(aa_ff);
   assign e_pos = !e[EW-1] && (e != '0);
   assign div_n = (step_ff == ST_GAIN_ANGLE) ? aa_ff : ba_ff;

   assign mul_start = (state_ff == S_MUL) && !busy_ff;
   assign div_start = (state_ff == S_DIV) && !busy_ff && e_pos;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (step_ff)
         ST_ANGLE_PRED: begin
            mul_a = OW'(gyro_ff) - OW'(bias_ff);
            mul_b = dt_op;
         end
         ST_AA_PRED: begin
            mul_a = OW'($signed({1'b0, apn_ff})) - OW'(ab_ff) - OW'(ba_ff);
            mul_b = dt_op;
         end
         ST_ABBA_PRED: begin
            mul_a = OW'(bb_ff);
            mul_b = dt_op;
         end
         ST_BB_PRED: begin
            mul_a = OW'($signed({1'b0, bpn_ff}));
            mul_b = dt_op;
         end
         ST_AA_UPD: begin
            mul_a = OW'(k0_ff);
            mul_b = OW'(t0_ff);
         end
         ST_AB_UPD: begin
            mul_a = OW'(k0_ff);
            mul_b = OW'(t1_ff);
         end
         ST_BA_UPD: begin
            mul_a = OW'(k1_ff);
            mul_b = OW'(t0_ff);
         end
         ST_BB_UPD: begin
            mul_a = OW'(k1_ff);
            mul_b = OW'(t1_ff);
         end
         ST_ANGLE_UPD: begin
            mul_a = OW'(k0_ff);
            mul_b = err_ff;
         end
         ST_BIAS_UPD: begin
            mul_a = OW'(k1_ff);
            mul_b = err_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   tak_mul #(.OW(OW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   tak_div #(.NW(WORD_BITS), .DENW(DENW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .n     (div_n),
      .d     (e[DENW-1:0]),
      .done  (div_done),
      .q     (div_q)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      apn_in       = apn_ff;
      bpn_in       = bpn_ff;
      mn_in        = mn_ff;
      dt_in        = dt_ff;
      accel_in     = accel_ff;
      gyro_in      = gyro_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      aa_in        = aa_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      out_angle_in = out_angle_ff;
      out_rate_in  = out_rate_ff;
      out_bias_in  = out_bias_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_ANGLE_NOISE: apn_in = csr_wdata;
            CSR_BIAS_NOISE:  bpn_in = csr_wdata;
            CSR_MEAS_NOISE:  mn_in  = csr_wdata;
            CSR_TIME_STEP:   dt_in  = csr_wdata;
            default:         apn_in = apn_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               accel_in = req_ch.accel_angle;
               gyro_in  = req_ch.gyro_rate;
               step_in  = ST_ANGLE_PRED;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_start) busy_in = 1'b1;
            if (mul_done) begin
               busy_in = 1'b0;
               step_in = step_type'(step_ff + 4'd1);
               unique case (step_ff)
                  ST_ANGLE_PRED: angle_in = acc_w(angle_ff, mul_prod, 1'b0);
                  ST_AA_PRED:    aa_in    = acc_w(aa_ff, mul_prod, 1'b0);
                  ST_ABBA_PRED: begin
                     ab_in = acc_w(ab_ff, mul_prod, 1'b1);
                     ba_in = acc_w(ba_ff, mul_prod, 1'b1);
                  end
                  ST_BB_PRED: begin
                     bb_in    = acc_w(bb_ff, mul_prod, 1'b0);
                     state_in = S_DIV;
                  end
                  ST_AA_UPD:     aa_in    = acc_w(aa_ff, mul_prod, 1'b1);
                  ST_AB_UPD:     ab_in    = acc_w(ab_ff, mul_prod, 1'b1);
                  ST_BA_UPD:     ba_in    = acc_w(ba_ff, mul_prod, 1'b1);
                  ST_BB_UPD:     bb_in    = acc_w(bb_ff, mul_prod, 1'b1);
                  ST_ANGLE_UPD:  angle_in = acc_w(angle_ff, mul_prod, 1'b0);
                  ST_BIAS_UPD: begin
                     bias_in  = acc_w(bias_ff, mul_prod, 1'b0);
                     state_in = S_OUT;
                  end
                  default:       state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            // on entry: freeze the predicted terms the update reuses
            if (!busy_ff && step_ff == ST_GAIN_ANGLE) begin
               t0_in  = aa_ff;
               t1_in  = ab_ff;
               err_in = OW'(accel_ff) - OW'(angle_ff);
               if (!e_pos) begin
                  k0_in    = '0;
                  k1_in    = '0;
                  step_in  = ST_AA_UPD;
                  state_in = S_MUL;
               end
            end
            if (div_start) busy_in = 1'b1;
            if (div_done) begin
               busy_in = 1'b0;
               if (step_ff == ST_GAIN_ANGLE) begin
                  k0_in   = div_q;
                  step_in = ST_GAIN_BIAS;
               end else begin
                  k1_in    = div_q;
                  step_in  = ST_AA_UPD;
                  state_in = S_MUL;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               out_angle_in = sat32(SUM_BITS'(angle_ff));
               out_rate_in  = sat32(SUM_BITS'(gyro_ff) - SUM_BITS'(bias_ff));
               out_bias_in  = sat32(SUM_BITS'(bias_ff));
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= ST_ANGLE_PRED;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         apn_ff       <= ANGLE_NOISE_RST;
         bpn_ff       <= BIAS_NOISE_RST;
         mn_ff        <= MEAS_NOISE_RST;
         dt_ff        <= TIME_STEP_RST;
         angle_ff     <= '0;
         bias_ff      <= '0;
         aa_ff        <= ONE_COV;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= ONE_COV;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         apn_ff       <= apn_in;
         bpn_ff       <= bpn_in;
         mn_ff        <= mn_in;
         dt_ff        <= dt_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
      end
   end

   always_ff @(posedge clock) begin
      accel_ff     <= accel_in;
      gyro_ff      <= gyro_in;
      k0_ff        <= k0_in;
      k1_ff        <= k1_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      err_ff       <= err_in;
      out_angle_ff <= out_angle_in;
      out_rate_ff  <= out_rate_in;
      out_bias_ff  <= out_bias_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.angle_estimate = out_angle_ff;
   assign rsp_ch.rate_estimate  = out_rate_ff;
   assign rsp_ch.bias_estimate  = out_bias_ff;
endmodule

FILE: rtl/tak_checker.sv
`timescale 1ns / 1ps
module tak_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_angle,
   input logic [31:0] rsp_rate,
   input logic [31:0] rsp_bias
);
   // one sample in flight: no second request beat right after one is taken
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is in work");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response pending after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle)
         && $stable(rsp_rate) && $stable(rsp_bias))
      else $error("stalled response beat changed");

   // the output register is refilled only once it was seen empty, so responses never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("response beats back to back");
endmodule

bind tilt_angle_kalman_filter_top tak_checker u_tak_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_angle (rsp_ch.angle_estimate),
   .rsp_rate  (rsp_ch.rate_estimate),
   .rsp_bias  (rsp_ch.bias_estimate)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tak_pkg::*;

   typedef struct packed {
      logic signed [31:0] accel;
      logic signed [31:0] gyro;
   } sample_t;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic signed [31:0] bias;
   } estimate_t;

   localparam longint ONE_Q30   = 64'sd1 << 30;
   localparam longint W_MAX     = 64'sd2147483647;
   localparam longint W_MIN     = -64'sd2147483648;
   localparam int     LIMIT_CYC = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_addr = '0;
   logic [CFG_BITS-1:0] csr_wdata = '0;

   tak_req_if req_ch ();
   tak_rsp_if rsp_ch ();

   tilt_angle_kalman_filter_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch.sink),
      .rsp_ch   (rsp_ch.source),
      .csr_we   (csr_we),
      .csr_addr (csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // filter model state and register copy
   logic [CFG_BITS-1:0] q_angle_noise, q_bias_noise, r_meas_noise, dt_step;
   longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;

   sample_t   pending_samples[$];
   estimate_t expected_estimates[$];
   int        n_errors = 0;
   int        n_samples = 0;
   int        n_beats = 0;
   int        n_cfg = 0;
   bit        no_gaps = 1'b0;
   longint    cycle_count = 0;

   function automatic longint sat_w(longint v);
      if (v > W_MAX) return W_MAX;
      if (v < W_MIN) return W_MIN;
      return v;
   endfunction

   function automatic logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   // (a*b) >> 30, round half away from zero, magnitude clamped to 2^62
   function automatic longint mul_round(longint a, longint b);
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      p = {64'd0, mag(a)} * {64'd0, mag(b)};
      p = (p + (128'd1 << 29)) >> 30;
      if (p > (128'd1 << 62)) p = 128'd1 << 62;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
   endfunction

   // (n << 30) / d, truncated, saturated to the word range
   function automatic longint gain_div(longint n, longint d);
      logic [127:0] q;
      q = ({64'd0, mag(n)} << 30) / {64'd0, 64'(d)};
      if (q > 128'(W_MAX)) q = 128'(W_MAX);
      return n < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic void filter_reset();
      q_angle_noise = ANGLE_NOISE_RST;
      q_bias_noise  = BIAS_NOISE_RST;
      r_meas_noise  = MEAS_NOISE_RST;
      dt_step       = TIME_STEP_RST;
      est_angle = 0;
      est_bias  = 0;
      p_aa = sat_w(ONE_Q30);
      p_ab = 0;
      p_ba = 0;
      p_bb = sat_w(ONE_Q30);
   endfunction

   function automatic estimate_t kalman_step(sample_t s);
      longint    acc, gyr, dt, pd0, innov, s_var, k0, k1, t0, t1;
      estimate_t r;
      acc = longint'(s.accel);
      gyr = longint'(s.gyro);
      dt  = longint'({1'b0, dt_step});
      k0 = 0;
      k1 = 0;
      est_angle = sat_w(est_angle + mul_round(gyr - est_bias, dt));
      pd0  = longint'({1'b0, q_angle_noise}) - p_ab - p_ba;
      p_aa = sat_w(p_aa + mul_round(pd0, dt));
      p_ab = sat_w(p_ab - mul_round(p_bb, dt));
      p_ba = sat_w(p_ba - mul_round(p_bb, dt));
      p_bb = sat_w(p_bb + mul_round(longint'({1'b0, q_bias_noise}), dt));
      innov = acc - est_angle;
      s_var = longint'({1'b0, r_meas_noise}) + p_aa;
      // non-positive innovation variance: gains stay zero
      if (s_var > 0) begin
         k0 = gain_div(p_aa, s_var);
         k1 = gain_div(p_ba, s_var);
      end
      t0 = p_aa;
      t1 = p_ab;
      p_aa = sat_w(p_aa - mul_round(k0, t0));
      p_ab = sat_w(p_ab - mul_round(k0, t1));
      p_ba = sat_w(p_ba - mul_round(k1, t0));
      p_bb = sat_w(p_bb - mul_round(k1, t1));
      est_angle = sat_w(est_angle + mul_round(k0, innov));
      est_bias  = sat_w(est_bias + mul_round(k1, innov));
      r.angle = 32'(sat_w(est_angle));
      r.rate  = 32'(sat_w(gyr - est_bias));
      r.bias  = 32'(sat_w(est_bias));
      return r;
   endfunction

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      sample_t s;
      bit      take;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         take = !req_ch.valid;
         if (req_ch.valid && req_ch.ready) begin
            s.accel = req_ch.accel_angle;
            s.gyro  = req_ch.gyro_rate;
            expected_estimates.push_back(kalman_step(s));
            n_samples++;
            req_gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
            take = 1'b1;
         end
         if (take) begin
            if (req_gap > 0) begin
               req_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               s = pending_samples.pop_front();
               req_ch.accel_angle <= s.accel;
               req_ch.gyro_rate   <= s.gyro;
               req_ch.valid       <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random stalls
   int rsp_hold = 0;
   always @(posedge clock) begin
      estimate_t e;
      int        hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         hold = rsp_hold;
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_beats++;
            if (expected_estimates.size() == 0) begin
               $display("%0t: unexpected beat angle=%0d rate=%0d bias=%0d", $time,
                        rsp_ch.angle_estimate, rsp_ch.rate_estimate, rsp_ch.bias_estimate);
               n_errors++;
            end else begin
               e = expected_estimates.pop_front();
               if (rsp_ch.angle_estimate !== e.angle) begin
                  $display("%0t: angle_estimate expected %0d actual %0d", $time, e.angle,
                           rsp_ch.angle_estimate);
                  n_errors++;
               end
               if (rsp_ch.rate_estimate !== e.rate) begin
                  $display("%0t: rate_estimate expected %0d actual %0d", $time, e.rate,
                           rsp_ch.rate_estimate);
                  n_errors++;
               end
               if (rsp_ch.bias_estimate !== e.bias) begin
                  $display("%0t: bias_estimate expected %0d actual %0d", $time, e.bias,
                           rsp_ch.bias_estimate);
                  n_errors++;
               end
            end
            // long back-pressure so the filter fills and stalls its input
            if (n_beats == 300 || n_beats == 1300) hold = 600;
            else if (no_gaps || $urandom_range(0, 3) == 0) hold = 0;
            else hold = $urandom_range(0, 17);
         end
         if (hold > 0) begin
            hold--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         rsp_hold = hold;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYC) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CFG_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      n_cfg++;
      case (idx)
         CSR_ANGLE_NOISE: q_angle_noise = val;
         CSR_BIAS_NOISE:  q_bias_noise  = val;
         CSR_MEAS_NOISE:  r_meas_noise  = val;
         default:         dt_step       = val;
      endcase
   endtask

   task automatic configure(logic [CFG_BITS-1:0] qa, logic [CFG_BITS-1:0] qb,
                            logic [CFG_BITS-1:0] rm, logic [CFG_BITS-1:0] dt);
      write_reg(CSR_ANGLE_NOISE, qa);
      write_reg(CSR_BIAS_NOISE, qb);
      write_reg(CSR_MEAS_NOISE, rm);
      write_reg(CSR_TIME_STEP, dt);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic queue_sample(logic [31:0] a, logic [31:0] g);
      sample_t s;
      s.accel = a;
      s.gyro  = g;
      pending_samples.push_back(s);
   endtask

   task automatic queue_random(int n);
      repeat (n) begin
         if ($urandom_range(0, 7) == 0) begin
            queue_sample($urandom, $urandom);
         end else begin
            // plausible tilt angles (+/-180 deg) and rates (+/-500 deg/s)
            queue_sample(32'($signed($urandom_range(0, 23592960)) - 11796480),
                         32'($signed($urandom_range(0, 65536000)) - 32768000));
         end
      end
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_ch.valid || expected_estimates.size() != 0)
         @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   function automatic logic [CFG_BITS-1:0] rand_cfg(logic [CFG_BITS-1:0] lo);
      logic [CFG_BITS-1:0] v;
      case ($urandom_range(0, 3))
         0: v = CFG_BITS'($urandom);
         1: v = CFG_BITS'($urandom_range(0, 1 << 24));
         2: v = CFG_BITS'($urandom_range(0, 1 << 28));
         default: v = CFG_BITS'($urandom_range(0, 1 << 16));
      endcase
      return v < lo ? lo : v;
   endfunction

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.accel_angle = '0;
      req_ch.gyro_rate   = '0;
      rsp_ch.ready       = 1'b0;
      filter_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults: directed corners, then random
      queue_sample(32'h0000_0000, 32'h0000_0000);
      queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_sample(32'h8000_0000, 32'h8000_0000);
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
      queue_sample(32'h0000_0001, 32'hFFFF_FFFF);
      queue_sample(32'hFFFF_FFFF, 32'h0000_0001);
      queue_sample(32'h005A_0000, 32'h0000_0000);
      queue_sample(32'hFFA6_0000, 32'h0064_0000);
      queue_sample(32'h0000_0000, 32'h0000_0000);
      queue_random(400);
      drain();

      // register maxima, back-to-back beats
      no_gaps = 1'b1;
      configure('1, '1, '1, '1);
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
      queue_random(150);
      drain();
      no_gaps = 1'b0;

      // register minima: zero noise and step, smallest measurement noise
      configure('0, '0, CFG_BITS'(1), '0);
      queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_random(150);
      drain();

      // large step with small measurement noise drives saturation
      configure(CFG_BITS'(1), '1, CFG_BITS'(1), '1);
      queue_random(150);
      drain();

      repeat (5) begin
         configure(rand_cfg('0), rand_cfg('0), rand_cfg(CFG_BITS'(1)), rand_cfg('0));
         queue_random(220);
         drain();
      end

      configure(ANGLE_NOISE_RST, BIAS_NOISE_RST, MEAS_NOISE_RST, TIME_STEP_RST);
      queue_random(100);
      drain();

      $display("covered %0d samples, %0d response beats, %0d register writes", n_samples,
               n_beats, n_cfg);
      $display("register sets: defaults, maxima, minima, saturating and random settings");
      if (n_errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
